>>> src/rmsn_pkg.sv
// Shared types and constants for the RMS normalization scale unit.
// No dependencies; the cfg interface, the step unit, the top level and the checker import this package.
package rmsn_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] REG_HIDDEN_DIM  = 2'd0;
    localparam logic [1:0] REG_RMS_EPSILON = 2'd1;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Opcodes on the input channel
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    // Datapath widths
    localparam int unsigned SUM_W   = 44;
    localparam int unsigned DIM_W   = 14;
    localparam int unsigned EPS_W   = 32;
    localparam int unsigned MEAN_W  = 45;
    localparam int unsigned NUM_W   = 58;
    localparam int unsigned REM_W   = 46;
    localparam int unsigned SCALE_W = 32;

    // Step counts of the shared divide / square-root unit
    localparam logic [5:0] DIV_STEPS  = 6'd58;
    localparam logic [5:0] SQRT_STEPS = 6'd29;

    typedef enum logic [0:0] {
        MODE_DIV  = 1'b0,
        MODE_SQRT = 1'b1
    } rmsn_mode_t;

    // Command from the sequencer to the shared unit
    typedef struct packed {
        logic               start;
        rmsn_mode_t         mode;
        logic [NUM_W-1:0]   dividend;
        logic [MEAN_W-1:0]  divisor;
    } rmsn_cmd_t;

    // Status from the shared unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } rmsn_sts_t;

endpackage

>>> src/rmsn_req_if.sv
// Input item channel: opcode, element and weight with valid/ready.
// Depends on nothing but the handshake convention.
interface rmsn_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] element;
    logic signed [15:0] weight;

    modport source (output valid, output opcode, output element, output weight, input ready);
    modport sink   (input valid, input opcode, input element, input weight, output ready);
endinterface

>>> src/rmsn_rsp_if.sv
// Result channel: normalized value and saturation flag with valid/ready.
// Depends on nothing but the handshake convention.
interface rmsn_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normalized;
    logic               saturated;

    modport source (output valid, output normalized, output saturated, input ready);
    modport sink   (input valid, input normalized, input saturated, output ready);
endinterface

>>> src/rmsn_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Uses the widths from rmsn_pkg.
interface rmsn_cfg_if;
    import rmsn_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/rmsn_step_unit.sv
// Shared shift/compare/subtract unit: restoring division or square root.
// Depends on rmsn_pkg for the command and status structs.
module rmsn_step_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rmsn_pkg::rmsn_cmd_t       cmd,
    output rmsn_pkg::rmsn_sts_t       sts,
    output logic [rmsn_pkg::NUM_W-1:0] result
);
    import rmsn_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    rmsn_mode_t         mode_reg;
    logic [5:0]         cnt_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [MEAN_W-1:0]  den_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   quo_reg;

    logic [REM_W-1:0]   shifted;
    logic [REM_W-1:0]   trial;
    logic               ge;
    logic [REM_W-1:0]   rem_next;
    logic [NUM_W-1:0]   quo_next;
    logic [NUM_W-1:0]   num_next;

    // One digit step: bring in the next dividend bits, try the subtract
    always_comb
    begin
        if (mode_reg == MODE_SQRT)
        begin
            shifted  = {rem_reg[REM_W-3:0], num_reg[NUM_W-1:NUM_W-2]};
            trial    = {quo_reg[REM_W-3:0], 2'b01};
            num_next = {num_reg[NUM_W-3:0], 2'b00};
        end
        else
        begin
            shifted  = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
            trial    = {1'b0, den_reg};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
        end
        ge       = (shifted >= trial);
        rem_next = ge ? (shifted - trial) : shifted;
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    // Control: load on start, count steps, pulse done after the last one
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg == 6'd1)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= cmd.mode;
            cnt_reg  <= (cmd.mode == MODE_SQRT) ? SQRT_STEPS : DIV_STEPS;
            num_reg  <= cmd.dividend;
            den_reg  <= cmd.divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = quo_reg;

endmodule

>>> src/rms_norm_scale_unit.sv
// RMS normalization scale unit: sequencer, accumulator and apply datapath.
// Depends on rmsn_pkg, the three channel interfaces and rmsn_step_unit.
//
// Use: stream a vector's elements with opcode 0 on req to accumulate the sum
// of squares, then stream them again with opcode 1 and a weight each; every
// apply beat returns one beat on rsp (normalized Q4.12 and a clip flag).
// Accumulate beats return nothing. Registers are written on cfg (hidden_dim
// at index 0, rms_epsilon at index 1); the user must write them only while
// the block is idle, which the block does not enforce. cfg is always ready.
// Timing: accumulate beats are taken back to back. An apply beat with the
// scale already known passes two multiplier stages and rounding, then its
// result goes to rsp. The first apply after an accumulate run first computes
// the inverse scale on the shared divide/square-root unit: a 58-step division
// by hidden_dim, a 58-step division of 2^56 by the mean, and a 29-step square
// root. req is not ready while an apply beat is in work.
// Reset: the sum, the scale and its flag clear, registers take their reset
// values, rsp goes empty.
// Stall: a result waits in the rsp register; the next beat is still taken,
// and an apply that finishes while rsp is full holds until it drains.
module rms_norm_scale_unit
#(
    parameter int unsigned MAX_DIM = 8192
)
(
    input  logic   clk,
    input  logic   rst_n,
    rmsn_req_if.sink   req,
    rmsn_rsp_if.source rsp,
    rmsn_cfg_if.sink   cfg
);
    import rmsn_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DIV_DIM   = 7'b0000010,
        ST_DIV_MEAN  = 7'b0000100,
        ST_SQRT      = 7'b0001000,
        ST_MUL_EW    = 7'b0010000,
        ST_MUL_SCALE = 7'b0100000,
        ST_ROUND     = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     hidden_dim_reg;
    logic [EPS_W-1:0]     rms_epsilon_reg;
    logic [SUM_W-1:0]     square_sum_reg, square_sum_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic                 scale_ready_reg, scale_ready_next;
    logic                 in_apply_reg, in_apply_next;
    logic [15:0]          emag_reg, wmag_reg;
    logic                 neg_reg;
    logic [31:0]          prod_ew_reg;
    logic [62:0]          prod_reg;
    logic                 rsp_valid_reg;
    logic [15:0]          rsp_value_reg;
    logic                 rsp_sat_reg;

    logic                 req_fire;
    logic [15:0]          emag_in, wmag_in;
    logic [31:0]          square;
    logic [SUM_W:0]       sum_add;
    logic [SUM_W-1:0]     sum_base;
    logic [31:0]          dim_ext;
    logic [DIM_W-1:0]     dim_val;
    logic [MEAN_W-1:0]    mean;
    logic [63:0]          rounded;
    logic [35:0]          mag;
    logic [15:0]          res_value;
    logic                 res_sat;
    logic                 rsp_load;
    rmsn_cmd_t            cmd;
    rmsn_sts_t            sts;
    logic [NUM_W-1:0]     unit_result;

    rmsn_step_unit u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .result (unit_result)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Magnitudes of the signed inputs
    assign emag_in = req.element[15] ? (~req.element + 16'd1) : req.element;
    assign wmag_in = req.weight[15]  ? (~req.weight + 16'd1)  : req.weight;

    // Saturating accumulate of the square
    assign square   = emag_in * emag_in;
    assign sum_base = in_apply_reg ? '0 : square_sum_reg;
    assign sum_add  = {1'b0, sum_base} + {{(SUM_W-31){1'b0}}, square};

    // Clamp the divisor to 1..MAX_DIM
    assign dim_ext = {{(32-DIM_W){1'b0}}, hidden_dim_reg};
    always_comb
    begin
        if (hidden_dim_reg == '0)
            dim_val = DIM_W'(1);
        else if (dim_ext > MAX_DIM)
            dim_val = DIM_W'(MAX_DIM);
        else
            dim_val = hidden_dim_reg;
    end

    assign mean = {1'b0, unit_result[SUM_W-1:0]}
                + {{(MEAN_W-EPS_W){1'b0}}, rms_epsilon_reg};

    // Round half away from zero and saturate to Q4.12
    assign rounded = {1'b0, prod_reg} + (64'd1 << 27);
    assign mag     = rounded[63:28];
    always_comb
    begin
        res_sat = 1'b0;
        if (mag == '0)
        begin
            res_value = '0;
        end
        else if (!neg_reg)
        begin
            if (mag > 36'd32767)
            begin
                res_value = 16'h7FFF;
                res_sat   = 1'b1;
            end
            else
            begin
                res_value = mag[15:0];
            end
        end
        else
        begin
            if (mag > 36'd32768)
            begin
                res_value = 16'h8000;
                res_sat   = 1'b1;
            end
            else
            begin
                res_value = ~mag[15:0] + 16'd1;
            end
        end
    end

    assign rsp_load = (state_reg == ST_ROUND) && (!rsp_valid_reg || rsp.ready);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        square_sum_next  = square_sum_reg;
        scale_next       = scale_reg;
        scale_ready_next = scale_ready_reg;
        in_apply_next    = in_apply_reg;
        cmd.start        = 1'b0;
        cmd.mode         = MODE_DIV;
        cmd.dividend     = {{(NUM_W-SUM_W){1'b0}}, square_sum_reg};
        cmd.divisor      = {{(MEAN_W-DIM_W){1'b0}}, dim_val};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.opcode == OP_ACCUM)
                begin
                    square_sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    if (in_apply_reg)
                    begin
                        scale_ready_next = 1'b0;
                        in_apply_next    = 1'b0;
                    end
                end
                else if (req_fire)
                begin
                    in_apply_next = 1'b1;
                    if (scale_ready_reg)
                    begin
                        state_next = ST_MUL_EW;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIV_DIM;
                    end
                end
            end
            ST_DIV_DIM:
            begin
                if (sts.done)
                begin
                    if (mean == '0)
                    begin
                        scale_next       = '1;
                        scale_ready_next = 1'b1;
                        state_next       = ST_MUL_EW;
                    end
                    else
                    begin
                        cmd.start    = 1'b1;
                        cmd.dividend = NUM_W'(1) << 56;
                        cmd.divisor  = mean;
                        state_next   = ST_DIV_MEAN;
                    end
                end
            end
            ST_DIV_MEAN:
            begin
                if (sts.done)
                begin
                    cmd.start    = 1'b1;
                    cmd.mode     = MODE_SQRT;
                    cmd.dividend = unit_result;
                    state_next   = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sts.done)
                begin
                    scale_next       = unit_result[SCALE_W-1:0];
                    scale_ready_next = 1'b1;
                    state_next       = ST_MUL_EW;
                end
            end
            ST_MUL_EW:
            begin
                state_next = ST_MUL_SCALE;
            end
            ST_MUL_SCALE:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rsp_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hidden_dim_reg  <= DIM_W'(4096);
            rms_epsilon_reg <= EPS_W'(17);
            square_sum_reg  <= '0;
            scale_reg       <= '0;
            scale_ready_reg <= 1'b0;
            in_apply_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            square_sum_reg  <= square_sum_next;
            scale_reg       <= scale_next;
            scale_ready_reg <= scale_ready_next;
            in_apply_reg    <= in_apply_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_HIDDEN_DIM)
                    hidden_dim_reg <= cfg.data[DIM_W-1:0];
                else if (cfg.index == REG_RMS_EPSILON)
                    rms_epsilon_reg <= cfg.data[EPS_W-1:0];
            end
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Apply datapath: hold operands, two multiplier stages, result register
    always_ff @(posedge clk)
    begin
        if (req_fire && req.opcode == OP_APPLY)
        begin
            emag_reg <= emag_in;
            wmag_reg <= wmag_in;
            neg_reg  <= req.element[15] ^ req.weight[15];
        end
        if (state_reg == ST_MUL_EW)
            prod_ew_reg <= emag_reg * wmag_reg;
        if (state_reg == ST_MUL_SCALE)
            prod_reg <= prod_ew_reg[30:0] * scale_reg;
        if (rsp_load)
        begin
            rsp_value_reg <= res_value;
            rsp_sat_reg   <= res_sat;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.normalized = rsp_value_reg;
    assign rsp.saturated  = rsp_sat_reg;

endmodule

>>> src/rmsn_checker.sv
// Port-level assertions for rms_norm_scale_unit and the bind that attaches them.
// Depends on the top level's ports and the opcodes in rmsn_pkg.
module rmsn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_opcode,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] rsp_normalized,
    input logic        rsp_saturated,
    input logic        cfg_ready
);
    import rmsn_pkg::*;

    // Hold a result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    // Drop ready while an apply beat is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode == OP_APPLY |=> !req_ready)
        else $error("req ready during apply work");

    // An accumulate beat never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode == OP_ACCUM && !rsp_valid |=> !rsp_valid)
        else $error("result after accumulate beat");

    // A clipped result sits at a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_saturated |->
            (rsp_normalized == 16'h7FFF || rsp_normalized == 16'h8000))
        else $error("saturated flag without limit value");

    // Configuration is always taken
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg not ready");

endmodule

bind rms_norm_scale_unit rmsn_checker u_rmsn_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_opcode     (req.opcode),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_normalized (rsp.normalized),
    .rsp_saturated  (rsp.saturated),
    .cfg_ready      (cfg.ready)
);
